@@ rtl/core/assert_macros.svh @@
// Assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/tts_pkg.sv @@
// Package for the tick task scheduler: types, codes and controller/datapath structs.
package tts_pkg;

  localparam int TABLE_DEPTH_DEF = 8;
  localparam int RESULT_CAP      = 8;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_START  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // read address select
  typedef enum logic [2:0] {
    RA_I,
    RA_LAST,
    RA_ZERO,
    RA_J1,
    RA_J2
  } ra_t;

  // what goes into the output register
  typedef enum logic [1:0] {
    EM_STATUS,
    EM_PEND,
    EM_PEND_LAST
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TK_RD,
    S_TK_UPD,
    S_TK_FIN,
    S_RM_RD,
    S_RM_CHK,
    S_RM_WR,
    S_SO_RD0,
    S_SO_LD,
    S_SO_CMP,
    S_SO_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [15:0] elapsed;
    logic        one_shot;
    logic [15:0] rank;
    logic        retired;
  } entry_t;

  typedef struct packed {
    logic    latch;
    logic    rd;
    ra_t     ra;
    logic    emit;
    emit_t   emit_sel;
    status_t status;
    logic    add_write;
    logic    tk_init;
    logic    tk_update;
    logic    rm_init;
    logic    i_dec;
    logic    rm_write;
    logic    st_init;
    logic    so_pass;
    logic    hold_load;
    logic    so_cmp;
    logic    so_end;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic id_zero;
    logic cnt_zero;
    logic cnt_full;
    logic cnt_le1;
    logic out_free;
    logic pend_valid;
    logic push_need;
    logic tk_end;
    logic match;
    logic i_zero;
    logic so_last;
    logic top_is2;
  } sts_t;

endpackage

@@ rtl/core/tts_in_if.sv @@
// Input channel interface: valid/ready plus one scheduler request.
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  task_id;
  logic [15:0] period;
  logic        one_shot;
  logic [15:0] priority_req;

  modport source (output valid, operation, task_id, period, one_shot, priority_req,
                  input ready);
  modport sink (input valid, operation, task_id, period, one_shot, priority_req,
                output ready);
endinterface

@@ rtl/core/tts_out_if.sv @@
// Result channel interface: valid/ready plus one scheduler result.
interface tts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       fired_valid;
  logic [7:0] fired_task;
  logic       last;

  modport source (output valid, status, fired_valid, fired_task, last, input ready);
  modport sink (input valid, status, fired_valid, fired_task, last, output ready);
endinterface

@@ rtl/core/tts_ctrl.sv @@
// Scheduler controller: sequences tick, add, remove and sort over the datapath.
module tts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tts_pkg::sts_t sts,
  output tts_pkg::cmd_t cmd
);

  tts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tts_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tts_pkg::S_DECODE;
      end
      tts_pkg::S_DECODE: begin
        case (sts.op)
          tts_pkg::OP_TICK: begin
            if (sts.cnt_zero) begin
              if (sts.out_free) state_nxt = tts_pkg::S_IDLE;
            end else begin
              state_nxt = tts_pkg::S_TK_RD;
            end
          end
          tts_pkg::OP_ADD: begin
            if (sts.out_free) state_nxt = tts_pkg::S_IDLE;
          end
          tts_pkg::OP_REMOVE: begin
            if (sts.id_zero || sts.cnt_zero) begin
              if (sts.out_free) state_nxt = tts_pkg::S_IDLE;
            end else begin
              state_nxt = tts_pkg::S_RM_RD;
            end
          end
          tts_pkg::OP_START: begin
            if (sts.cnt_le1) begin
              if (sts.out_free) state_nxt = tts_pkg::S_IDLE;
            end else begin
              state_nxt = tts_pkg::S_SO_RD0;
            end
          end
          default: state_nxt = tts_pkg::S_IDLE;
        endcase
      end
      tts_pkg::S_TK_RD: state_nxt = tts_pkg::S_TK_UPD;
      tts_pkg::S_TK_UPD: begin
        if (!(sts.push_need && !sts.out_free)) begin
          state_nxt = sts.tk_end ? tts_pkg::S_TK_FIN : tts_pkg::S_TK_RD;
        end
      end
      tts_pkg::S_TK_FIN: begin
        if (sts.out_free) state_nxt = tts_pkg::S_IDLE;
      end
      tts_pkg::S_RM_RD: state_nxt = tts_pkg::S_RM_CHK;
      tts_pkg::S_RM_CHK: begin
        if (sts.match) state_nxt = tts_pkg::S_RM_WR;
        else state_nxt = sts.i_zero ? tts_pkg::S_DONE : tts_pkg::S_RM_RD;
      end
      tts_pkg::S_RM_WR: state_nxt = sts.i_zero ? tts_pkg::S_DONE : tts_pkg::S_RM_RD;
      tts_pkg::S_SO_RD0: state_nxt = tts_pkg::S_SO_LD;
      tts_pkg::S_SO_LD: state_nxt = tts_pkg::S_SO_CMP;
      tts_pkg::S_SO_CMP: begin
        if (sts.so_last) state_nxt = tts_pkg::S_SO_END;
      end
      tts_pkg::S_SO_END: state_nxt = sts.top_is2 ? tts_pkg::S_DONE : tts_pkg::S_SO_RD0;
      tts_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = tts_pkg::S_IDLE;
      end
      default: state_nxt = tts_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.ra       = tts_pkg::RA_I;
    cmd.emit_sel = tts_pkg::EM_STATUS;
    cmd.status   = tts_pkg::ST_OK;
    in_ready     = 1'b0;
    case (state_r)
      tts_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      tts_pkg::S_DECODE: begin
        case (sts.op)
          tts_pkg::OP_TICK: begin
            if (sts.cnt_zero) begin
              cmd.emit   = sts.out_free;
              cmd.status = tts_pkg::ST_EMPTY;
            end else begin
              cmd.tk_init = 1'b1;
            end
          end
          tts_pkg::OP_ADD: begin
            cmd.emit = sts.out_free;
            if (sts.id_zero) begin
              cmd.status = tts_pkg::ST_INVALID;
            end else if (sts.cnt_full) begin
              cmd.status = tts_pkg::ST_FULL;
            end else begin
              cmd.add_write = sts.out_free;
            end
          end
          tts_pkg::OP_REMOVE: begin
            if (sts.id_zero) begin
              cmd.emit   = sts.out_free;
              cmd.status = tts_pkg::ST_INVALID;
            end else if (sts.cnt_zero) begin
              cmd.emit   = sts.out_free;
              cmd.status = tts_pkg::ST_EMPTY;
            end else begin
              cmd.rm_init = 1'b1;
            end
          end
          tts_pkg::OP_START: begin
            if (sts.cnt_le1) begin
              cmd.emit = sts.out_free;
            end else begin
              cmd.st_init = 1'b1;
            end
          end
          default: ;
        endcase
      end
      tts_pkg::S_TK_RD: begin
        cmd.rd = 1'b1;
        cmd.ra = tts_pkg::RA_I;
      end
      tts_pkg::S_TK_UPD: begin
        if (!(sts.push_need && !sts.out_free)) begin
          cmd.tk_update = 1'b1;
          cmd.emit      = sts.push_need;
          cmd.emit_sel  = tts_pkg::EM_PEND;
        end
      end
      tts_pkg::S_TK_FIN: begin
        cmd.emit     = sts.out_free;
        cmd.emit_sel = sts.pend_valid ? tts_pkg::EM_PEND_LAST : tts_pkg::EM_STATUS;
      end
      tts_pkg::S_RM_RD: begin
        cmd.rd = 1'b1;
        cmd.ra = tts_pkg::RA_I;
      end
      tts_pkg::S_RM_CHK: begin
        if (sts.match) begin
          cmd.rd = 1'b1;
          cmd.ra = tts_pkg::RA_LAST;
        end else begin
          cmd.i_dec = !sts.i_zero;
        end
      end
      tts_pkg::S_RM_WR: begin
        cmd.rm_write = 1'b1;
        cmd.i_dec    = !sts.i_zero;
      end
      tts_pkg::S_SO_RD0: begin
        cmd.rd      = 1'b1;
        cmd.ra      = tts_pkg::RA_ZERO;
        cmd.so_pass = 1'b1;
      end
      tts_pkg::S_SO_LD: begin
        cmd.hold_load = 1'b1;
        cmd.rd        = 1'b1;
        cmd.ra        = tts_pkg::RA_J1;
      end
      tts_pkg::S_SO_CMP: begin
        cmd.so_cmp = 1'b1;
        cmd.rd     = !sts.so_last;
        cmd.ra     = tts_pkg::RA_J2;
      end
      tts_pkg::S_SO_END: cmd.so_end = 1'b1;
      tts_pkg::S_DONE: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/tts_dpath.sv @@
// Scheduler datapath: task table memory, walk counters, sort hold and result register.
`include "assert_macros.svh"

module tts_dpath #(
  parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tts_pkg::cmd_t cmd,
  output tts_pkg::sts_t sts,
  input  logic [1:0]    in_operation,
  input  logic [7:0]    in_task_id,
  input  logic [15:0]   in_period,
  input  logic          in_one_shot,
  input  logic [15:0]   in_priority_req,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic          out_fired_valid,
  output logic [7:0]    out_fired_task,
  output logic          out_last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(tts_pkg::RESULT_CAP + 1);

  tts_pkg::entry_t mem [TABLE_DEPTH];
  tts_pkg::entry_t rdata_r;
  tts_pkg::entry_t hold_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] top_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] j_r;
  logic [NW-1:0] n_r;
  logic          pend_valid_r;
  logic [7:0]    pend_task_r;

  tts_pkg::op_t op_r;
  logic [7:0]   id_r;
  logic [15:0]  period_r;
  logic         one_shot_r;
  logic [15:0]  rank_r;

  logic             out_valid_r;
  tts_pkg::status_t out_status_r;
  logic             out_fv_r;
  logic [7:0]       out_task_r;
  logic             out_last_r;

  // derived values
  logic [15:0]     el1;
  logic            hit, fire_live, sole, report, swap, out_free, cnt_full;
  logic [CW-1:0]   cnt_m1, top_m1;
  logic [CW:0]     j_p1, j_p2;
  tts_pkg::entry_t upd_e;

  assign el1       = rdata_r.elapsed + 16'd1;
  assign hit       = (el1 == rdata_r.period);
  assign fire_live = hit && !rdata_r.retired;
  assign sole      = fire_live && rdata_r.one_shot && (count_r == CW'(1));
  assign report    = fire_live && (n_r < NW'(tts_pkg::RESULT_CAP));
  assign swap      = hold_r.rank > rdata_r.rank;
  assign cnt_m1    = count_r - CW'(1);
  assign top_m1    = top_r - CW'(1);
  assign j_p1      = (CW+1)'(j_r) + (CW+1)'(1);
  assign j_p2      = (CW+1)'(j_r) + (CW+1)'(2);
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_full  = count_r >= CW'(TABLE_DEPTH);

  always_comb begin
    upd_e         = rdata_r;
    upd_e.elapsed = hit ? 16'd0 : el1;
    upd_e.retired = rdata_r.retired || (fire_live && rdata_r.one_shot && !sole);
  end

  // memory ports
  logic            we;
  logic [IW-1:0]   waddr, raddr;
  tts_pkg::entry_t wdata;

  always_comb begin
    we    = 1'b0;
    waddr = i_r;
    wdata = rdata_r;
    if (cmd.add_write) begin
      we    = 1'b1;
      waddr = count_r[IW-1:0];
      wdata = '{task_id: id_r, period: period_r, elapsed: 16'd0,
                one_shot: one_shot_r, rank: rank_r, retired: 1'b0};
    end else if (cmd.tk_update) begin
      we    = 1'b1;
      wdata = upd_e;
    end else if (cmd.rm_write) begin
      we    = 1'b1;
    end else if (cmd.so_cmp) begin
      we    = 1'b1;
      waddr = j_r;
      wdata = swap ? rdata_r : hold_r;
    end else if (cmd.so_end) begin
      we    = 1'b1;
      waddr = top_m1[IW-1:0];
      wdata = hold_r;
    end
  end

  always_comb begin
    case (cmd.ra)
      tts_pkg::RA_I:    raddr = i_r;
      tts_pkg::RA_LAST: raddr = cnt_m1[IW-1:0];
      tts_pkg::RA_ZERO: raddr = '0;
      tts_pkg::RA_J1:   raddr = j_p1[IW-1:0];
      tts_pkg::RA_J2:   raddr = j_p2[IW-1:0];
      default:          raddr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata_r <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.add_write) count_r <= count_r + CW'(1);
      else if (cmd.rm_write) count_r <= cnt_m1;
      else if (cmd.tk_update && sole) count_r <= '0;
      if (cmd.tk_init) pend_valid_r <= 1'b0;
      else if (cmd.tk_update && report) pend_valid_r <= 1'b1;
    end
  end

  // walk indexes, sort hold, pending firing
  always_ff @(posedge clk) begin
    if (cmd.tk_init) i_r <= '0;
    else if (cmd.tk_update) i_r <= i_r + IW'(1);
    else if (cmd.rm_init) i_r <= cnt_m1[IW-1:0];
    else if (cmd.i_dec) i_r <= i_r - IW'(1);

    if (cmd.tk_init) n_r <= '0;
    else if (cmd.tk_update && report) n_r <= n_r + NW'(1);
    if (cmd.tk_update && report) pend_task_r <= rdata_r.task_id;

    if (cmd.so_pass) j_r <= '0;
    else if (cmd.so_cmp) j_r <= j_p1[IW-1:0];

    if (cmd.st_init) top_r <= count_r;
    else if (cmd.so_end) top_r <= top_m1;

    if (cmd.hold_load) hold_r <= rdata_r;
    else if (cmd.so_cmp) hold_r <= swap ? hold_r : rdata_r;

    if (cmd.latch) begin
      op_r       <= tts_pkg::op_t'(in_operation);
      id_r       <= in_task_id;
      period_r   <= in_period;
      one_shot_r <= in_one_shot;
      rank_r     <= in_priority_req;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        tts_pkg::EM_PEND, tts_pkg::EM_PEND_LAST: begin
          out_status_r <= tts_pkg::ST_OK;
          out_fv_r     <= 1'b1;
          out_task_r   <= pend_task_r;
          out_last_r   <= (cmd.emit_sel == tts_pkg::EM_PEND_LAST);
        end
        default: begin
          out_status_r <= cmd.status;
          out_fv_r     <= 1'b0;
          out_task_r   <= 8'd0;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_fired_valid = out_fv_r;
  assign out_fired_task  = out_task_r;
  assign out_last        = out_last_r;

  // status to controller
  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.id_zero    = (id_r == 8'd0);
    sts.cnt_zero   = (count_r == '0);
    sts.cnt_full   = cnt_full;
    sts.cnt_le1    = (count_r <= CW'(1));
    sts.out_free   = out_free;
    sts.pend_valid = pend_valid_r;
    sts.push_need  = report && pend_valid_r;
    sts.tk_end     = sole || (CW'(i_r) == cnt_m1);
    sts.match      = !rdata_r.retired && (rdata_r.task_id == id_r);
    sts.i_zero     = (i_r == '0);
    sts.so_last    = (j_p2 >= (CW+1)'(top_r));
    sts.top_is2    = (top_r == CW'(2));
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= CW'(TABLE_DEPTH))
  `ASSERT_IMPLY(a_emit_room, clk, rst_n, cmd.emit, out_free)
  `ASSERT_IMPLY(a_add_room, clk, rst_n, cmd.add_write, !cnt_full)
  `ASSERT_IMPLY(a_fire_ok, clk, rst_n, out_valid_r && out_fv_r, out_status_r == tts_pkg::ST_OK)

endmodule

@@ rtl/core/tick_task_scheduler_table.sv @@
// Top level of the tick task scheduler table: controller plus table datapath.
// Tick does one read and one write-back per entry; remove reads each entry in turn
// and rewrites only on a match; start sorts the table in passes.
// One request at a time; the next is taken while the final result waits in the output.
// rst_n is synchronous: table empty, no result pending; table memory is not cleared.
module tick_task_scheduler_table #(
  parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  tts_in_if.sink   in_chan,
  tts_out_if.source out_chan
);

  // command and status between the sequencer and the table
  tts_pkg::cmd_t cmd;
  tts_pkg::sts_t sts;

  // Controller: accepts a transfer only in its idle state, then walks the
  // table with at most one read and one write per step.
  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: table memory, entry count, walk indexes, the pending firing
  // that lets the last result of a tick carry its last flag, and the output
  // register that decouples the result side.
  tts_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_chan.operation),
    .in_task_id      (in_chan.task_id),
    .in_period       (in_chan.period),
    .in_one_shot     (in_chan.one_shot),
    .in_priority_req (in_chan.priority_req),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_status      (out_chan.status),
    .out_fired_valid (out_chan.fired_valid),
    .out_fired_task  (out_chan.fired_task),
    .out_last        (out_chan.last)
  );

endmodule

@@ verif/tick_task_scheduler_table_checker.sv @@
// Scoreboard for the tick task scheduler: mirrors the task table and checks every result.
`timescale 1ns / 100ps

module tick_task_scheduler_table_checker #(
  parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tts_in_if    in_mon,
  tts_out_if   out_mon,
  output int   fail_count,
  output int   results_due
);

  typedef struct packed {
    tts_pkg::status_t status;
    logic             fired_valid;
    logic [7:0]       fired_task;
    logic             last;
  } sched_result_t;

  tts_pkg::entry_t task_slots [TABLE_DEPTH];
  int              live_count;
  sched_result_t   due_results [$];

  function automatic sched_result_t mk_result(tts_pkg::status_t st, logic fv,
                                              logic [7:0] tid, logic lst);
    sched_result_t r;
    r.status      = st;
    r.fired_valid = fv;
    r.fired_task  = tid;
    r.last        = lst;
    return r;
  endfunction

  // advance every entry by one tick, queue each firing up to RESULT_CAP
  task automatic run_tick();
    int fired;
    int i;
    bit emptied;
    fired   = 0;
    emptied = 0;
    i       = 0;
    if (live_count == 0) begin
      due_results.push_back(mk_result(tts_pkg::ST_EMPTY, 1'b0, 8'd0, 1'b1));
      return;
    end
    while (i < live_count && !emptied) begin
      task_slots[i].elapsed = task_slots[i].elapsed + 16'd1;
      if (task_slots[i].elapsed == task_slots[i].period) begin
        task_slots[i].elapsed = 16'd0;
        if (!task_slots[i].retired) begin
          if (fired < tts_pkg::RESULT_CAP) begin
            due_results.push_back(mk_result(tts_pkg::ST_OK, 1'b1, task_slots[i].task_id,
                                            1'b0));
            fired++;
          end
          if (task_slots[i].one_shot) begin
            // sole one-shot entry clears the table, else it just retires
            if (live_count == 1) begin
              live_count = 0;
              emptied    = 1;
            end else begin
              task_slots[i].retired = 1'b1;
            end
          end
        end
      end
      i++;
    end
    if (fired == 0)
      due_results.push_back(mk_result(tts_pkg::ST_OK, 1'b0, 8'd0, 1'b1));
    else
      due_results[due_results.size() - 1].last = 1'b1;
  endtask

  task automatic run_request(tts_pkg::op_t op, logic [7:0] tid, logic [15:0] per, logic os,
                             logic [15:0] rank);
    tts_pkg::status_t st;
    int               i;
    int               top;
    tts_pkg::entry_t  tmp;
    st = tts_pkg::ST_OK;
    case (op)
      tts_pkg::OP_TICK: begin
        run_tick();
        return;
      end
      tts_pkg::OP_ADD: begin
        if (tid == 8'd0) begin
          st = tts_pkg::ST_INVALID;
        end else if (live_count >= TABLE_DEPTH) begin
          st = tts_pkg::ST_FULL;
        end else begin
          task_slots[live_count] = '{task_id: tid, period: per, elapsed: 16'd0,
                                     one_shot: os, rank: rank, retired: 1'b0};
          live_count++;
        end
      end
      tts_pkg::OP_REMOVE: begin
        if (tid == 8'd0) begin
          st = tts_pkg::ST_INVALID;
        end else if (live_count == 0) begin
          st = tts_pkg::ST_EMPTY;
        end else begin
          // top-down scan, last entry moves into each hole
          i = live_count;
          while (i > 0) begin
            i--;
            if (!task_slots[i].retired && task_slots[i].task_id == tid) begin
              task_slots[i] = task_slots[live_count - 1];
              live_count--;
            end
          end
        end
      end
      default: begin
        // stable bubble sort on rank
        for (top = live_count; top > 1; top--) begin
          for (i = 0; i + 1 < top; i++) begin
            if (task_slots[i].rank > task_slots[i + 1].rank) begin
              tmp               = task_slots[i];
              task_slots[i]     = task_slots[i + 1];
              task_slots[i + 1] = tmp;
            end
          end
        end
      end
    endcase
    due_results.push_back(mk_result(st, 1'b0, 8'd0, 1'b1));
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst_n) begin
      live_count = 0;
      due_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        run_request(tts_pkg::op_t'(in_mon.operation), in_mon.task_id, in_mon.period,
                    in_mon.one_shot, in_mon.priority_req);
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: status %0d fired %0d task %0d last %0d",
                 out_mon.status, out_mon.fired_valid, out_mon.fired_task, out_mon.last);
          fail_count++;
        end else begin
          exp_r = due_results.pop_front();
          check_field("status", exp_r.status, out_mon.status);
          check_field("fired_valid", exp_r.fired_valid, out_mon.fired_valid);
          check_field("fired_task", exp_r.fired_task, out_mon.fired_task);
          check_field("last", exp_r.last, out_mon.last);
        end
      end
    end
    results_due = due_results.size();
  end

endmodule

@@ verif/tick_task_scheduler_table_tb.sv @@
// Testbench top for the tick task scheduler table: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tick_task_scheduler_table_tb;

  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, enough to back up the input
  localparam int DRAIN_CYCLES = 100;  // beyond the slowest request (sort of a full table)
  localparam int PHASE_ITEMS  = 51;   // four phases, 204 random requests

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int fail_count;
  int results_due;

  // idle percentages, changed only between phases
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // hold-off requests: top bumps hold_seq, receiver process owns the countdown
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  tts_in_if  in_chan();
  tts_out_if out_chan();

  tick_task_scheduler_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tick_task_scheduler_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: ready changes on the falling edge. A pending hold-off request
  // wins over random stalls and keeps ready low for the whole stretch.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else if (hold_seq != hold_seen) begin
        hold_seen      = hold_seq;
        hold_left      = HOLD_CYCLES - 1;
        out_chan.ready = 1'b0;
      end else begin
        out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One request transfer. Called at a falling edge, returns at the falling edge
  // after the transfer, so back-to-back calls without idling keep valid high without a dip.
  task automatic send_req(tts_pkg::op_t op, logic [7:0] tid, logic [15:0] per, logic os,
                          logic [15:0] rank);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid        = 1'b1;
    in_chan.operation    = op;
    in_chan.task_id      = tid;
    in_chan.period       = per;
    in_chan.one_shot     = os;
    in_chan.priority_req = rank;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every expected result has come back.
  task automatic wait_drained();
    in_chan.valid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Random request. Ids mostly come from a small pool so removes hit and
  // duplicates pile up; short periods keep ticks firing often.
  task automatic send_random();
    tts_pkg::op_t op;
    logic [7:0]   tid;
    logic [15:0]  per;
    logic [15:0]  rank;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 50)      op = tts_pkg::OP_TICK;
    else if (pick < 75) op = tts_pkg::OP_ADD;
    else if (pick < 90) op = tts_pkg::OP_REMOVE;
    else                op = tts_pkg::OP_START;
    pick = $urandom_range(99);
    if (pick < 85)      tid = 8'($urandom_range(1, 6));
    else if (pick < 90) tid = 8'd0;
    else                tid = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 75)      per = 16'($urandom_range(1, 6));
    else if (pick < 85) per = 16'($urandom_range(65535));
    else if (pick < 93) per = 16'hFFFF;
    else if (pick < 97) per = 16'd0;
    else                per = 16'd1;
    // narrow ranks give equal keys, which exercises sort stability
    if ($urandom_range(99) < 40) rank = 16'($urandom_range(3));
    else                         rank = 16'($urandom_range(65535));
    send_req(op, tid, per, 1'($urandom_range(99) < 30), rank);
  endtask

  initial begin
    in_chan.valid        = 1'b0;
    in_chan.operation    = tts_pkg::OP_TICK;
    in_chan.task_id      = 8'd0;
    in_chan.period       = 16'd0;
    in_chan.one_shot     = 1'b0;
    in_chan.priority_req = 16'd0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-table cases and rejected ids
    send_req(tts_pkg::OP_TICK,   8'd0, 16'd0, 1'b0, 16'd0);  // tick on empty table
    send_req(tts_pkg::OP_REMOVE, 8'd5, 16'd0, 1'b0, 16'd0);  // remove on empty table
    send_req(tts_pkg::OP_START,  8'd0, 16'd0, 1'b0, 16'd0);  // start on empty table
    send_req(tts_pkg::OP_ADD,    8'd0, 16'd3, 1'b0, 16'd0);  // add with id zero
    send_req(tts_pkg::OP_REMOVE, 8'd0, 16'd0, 1'b0, 16'd0);  // remove with id zero
    // sole one-shot entry fires and empties the table
    send_req(tts_pkg::OP_ADD,    8'd9, 16'd1, 1'b1, 16'd0);
    send_req(tts_pkg::OP_TICK,   8'd0, 16'd0, 1'b0, 16'd0);
    send_req(tts_pkg::OP_TICK,   8'd0, 16'd0, 1'b0, 16'd0);
    // fill all eight slots, field extremes included
    send_req(tts_pkg::OP_ADD, 8'd255, 16'hFFFF, 1'b0, 16'hFFFF);
    send_req(tts_pkg::OP_ADD, 8'd1,   16'd1,    1'b0, 16'h8000);
    send_req(tts_pkg::OP_ADD, 8'd2,   16'd2,    1'b1, 16'd5);
    send_req(tts_pkg::OP_ADD, 8'd3,   16'd1,    1'b0, 16'd5);
    send_req(tts_pkg::OP_ADD, 8'd1,   16'd3,    1'b0, 16'd0);
    send_req(tts_pkg::OP_ADD, 8'd4,   16'd2,    1'b1, 16'h7FFF);
    send_req(tts_pkg::OP_ADD, 8'd5,   16'd1,    1'b0, 16'd1);
    send_req(tts_pkg::OP_ADD, 8'd6,   16'd0,    1'b0, 16'd2);
    send_req(tts_pkg::OP_ADD, 8'd7,   16'd1,    1'b0, 16'd0);     // table full
    send_req(tts_pkg::OP_START, 8'd0, 16'd0, 1'b0, 16'd0);
    send_req(tts_pkg::OP_TICK,  8'd0, 16'd0, 1'b0, 16'd0);
    send_req(tts_pkg::OP_TICK,  8'd0, 16'd0, 1'b0, 16'd0);        // one-shots retire here
    send_req(tts_pkg::OP_TICK,  8'd0, 16'd0, 1'b0, 16'd0);
    send_req(tts_pkg::OP_REMOVE, 8'd1, 16'd0, 1'b0, 16'd0);       // two matches
    send_req(tts_pkg::OP_REMOVE, 8'd200, 16'd0, 1'b0, 16'd0);     // no match, still ok
    send_req(tts_pkg::OP_ADD, 8'h80, 16'h8000, 1'b1, 16'h0001);
    send_req(tts_pkg::OP_TICK,  8'd0, 16'd0, 1'b0, 16'd0);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // long receiver hold-off at the start of the first phase: the sender keeps
      // offering, so the block backs up and stalls its input
      if (phase == 0) hold_seq++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random();
        if (n == PHASE_ITEMS / 2 && phase == 2) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_in_if.sv
rtl/core/tts_out_if.sv
rtl/core/tts_ctrl.sv
rtl/core/tts_dpath.sv
rtl/core/tick_task_scheduler_table.sv
verif/tick_task_scheduler_table_checker.sv
verif/tick_task_scheduler_table_tb.sv
